### sv/ftue_pkg.sv
// ----------------------------------------------------------------------------
// ftue_pkg: shared types and constants for the flow table
// Table sizing, stream layout, status and opcode values, entry types.
// ----------------------------------------------------------------------------
package ftue_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int USED_W      = IDX_W + 1;      // holds 0..TABLE_DEPTH
    localparam int ENTRY_W     = 8;              // entry_index field
    localparam int EXP_W       = 9;              // expired_count field

    localparam logic [63:0] TIMEOUT_RESET = 64'd30000000000;

    // status codes
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_NEW   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    // opcodes and IP versions
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_SWEEP  = 1'b1;
    localparam logic VER_IPV4  = 1'b0;

    // stream widths and output field offsets
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TUSER_W  = 2;
    localparam int OUT_TDATA_W  = 152;
    localparam int OUT_IDX_LSB  = 0;
    localparam int OUT_PKT_LSB  = 8;
    localparam int OUT_BYTE_LSB = 72;
    localparam int OUT_EXP_LSB  = 136;

    // input tdata, first field in the highest bits
    typedef struct packed {
        logic [63:0] now_ns;
        logic [15:0] pkt_len;
        logic [63:0] dest_addr_lo;
        logic [63:0] dest_addr_hi;
        logic [63:0] source_addr_lo;
        logic [63:0] source_addr_hi;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [7:0]  protocol;
    } t_in_data;

    localparam int IN_TDATA_W = $bits(t_in_data);

    typedef struct packed {
        logic        ip_ver;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
    } t_key;

    typedef struct packed {
        logic [63:0] pkt_cnt;
        logic [63:0] byte_cnt;
        logic [63:0] last_ns;
    } t_stat;

    typedef struct packed {
        t_key  key;
        t_stat stat;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

endpackage

### sv/flow_table_update_expire.sv
// ----------------------------------------------------------------------------
// flow_table_update_expire: 5-tuple packet flow table with idle expiry
// Update transfers count packets per flow; sweep transfers age out flows.
// ----------------------------------------------------------------------------
// Each input transfer is a packet update (tuser[0] = 0) or an expiry sweep
// (tuser[0] = 1) and yields exactly one result transfer. The block walks the
// used slots of one entry RAM in slot order, one slot per cycle through the
// RAM's registered read port; a hit ends the walk and passes through the
// packet count and byte count steps. The result then waits until the output
// register is free. The input is ready again in the cycle after the result is
// loaded, and only while no item is in work; a finished result sits in the
// output register so the next transfer can be taken meanwhile. A single
// 64-bit adder serves the idle-time subtract during sweeps and the packet and
// byte counter increments on a hit. Slots freed by a sweep are not reused;
// the table fills by append. Live marks and the fill count clear at reset, no
// clearing pass is needed. The idle timeout is written on i_cfg_we and should
// only change while the block is idle.
// ----------------------------------------------------------------------------
module flow_table_update_expire
    import ftue_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config: idle timeout in ns
    input  logic                   i_cfg_we,
    input  logic [63:0]            i_cfg_wdata,
    // request stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: protocol, source_port, dest_port, source_addr_hi,
    //        source_addr_lo, dest_addr_hi, dest_addr_lo, pkt_len, now_ns
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: op, ip_ver
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: entry_index, packet_count, byte_count, expired_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_SCAN = 3'd1;  // walking the used slots
    localparam logic [2:0] S_PKT  = 3'd2;  // hit: packet count + 1
    localparam logic [2:0] S_BYTE = 3'd3;  // hit: byte count + len, write back
    localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

    // IPv4 keys only look at the low 32 bits of the lo address words
    function automatic logic key_match(input t_key a, input t_key b);
        logic meta_eq;
        meta_eq = (a.ip_ver == b.ip_ver) && (a.protocol == b.protocol) &&
                  (a.source_port == b.source_port) && (a.dest_port == b.dest_port);
        if (a.ip_ver == VER_IPV4) begin
            return meta_eq && (a.src_lo[31:0] == b.src_lo[31:0]) &&
                   (a.dst_lo[31:0] == b.dst_lo[31:0]);
        end
        return meta_eq && (a.src_hi == b.src_hi) && (a.src_lo == b.src_lo) &&
               (a.dst_hi == b.dst_hi) && (a.dst_lo == b.dst_lo);
    endfunction

    // control state
    logic [2:0]             r_state, n_state;
    logic [63:0]            r_timeout, n_timeout;
    logic [USED_W-1:0]      r_used, n_used;
    logic [TABLE_DEPTH-1:0] r_live, n_live;
    logic [USED_W-1:0]      r_rd_idx, n_rd_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic                   r_ovalid, n_ovalid;

    // payload
    logic                   r_op, n_op;
    t_key                   r_key, n_key;
    logic [15:0]            r_len, n_len;
    logic [63:0]            r_now, n_now;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;
    logic [USED_W-1:0]      r_exp, n_exp;
    logic [63:0]            r_pkt_sum, n_pkt_sum;
    logic [1:0]             r_res_status, n_res_status;
    logic [ENTRY_W-1:0]     r_res_idx, n_res_idx;
    logic [63:0]            r_res_pkt, n_res_pkt;
    logic [63:0]            r_res_byte, n_res_byte;
    logic [EXP_W-1:0]       r_res_exp, n_res_exp;
    logic [1:0]             r_o_status, n_o_status;
    logic [ENTRY_W-1:0]     r_o_idx, n_o_idx;
    logic [63:0]            r_o_pkt, n_o_pkt;
    logic [63:0]            r_o_byte, n_o_byte;
    logic [EXP_W-1:0]       r_o_exp, n_o_exp;

    // RAM port
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    t_entry                 ram_wdata;
    logic                   ram_re;
    logic [ENTRY_BITS-1:0]  ram_q;
    t_entry                 rd_ent;

    // shared adder
    logic [63:0]            add_a, add_b, add_sum;
    logic                   add_cin;

    t_in_data               in_data;
    logic                   in_xfer, out_xfer;
    logic                   in_scan, hit_now, expire_now, scan_end;

    assign in_data  = t_in_data'(s_axis_tdata);
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign rd_ent   = t_entry'(ram_q);
    assign in_scan  = (r_state == S_SCAN);

    ftue_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_q)
    );

    // shared adder: idle time during sweep scans, counter bumps on a hit
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                add_a   = r_now;
                add_b   = ~rd_ent.stat.last_ns;
                add_cin = 1'b1;
            end
            S_PKT: begin
                add_a   = rd_ent.stat.pkt_cnt;
                add_cin = 1'b1;
            end
            S_BYTE: begin
                add_a = rd_ent.stat.byte_cnt;
                add_b = 64'(r_len);
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
        add_sum = add_a + add_b + 64'(add_cin);
    end

    // compare stage works on the slot read in the previous cycle
    assign hit_now    = in_scan && r_cmp_vld && (r_op == OP_UPDATE) &&
                        r_live[r_cmp_idx] && key_match(r_key, rd_ent.key);
    assign expire_now = in_scan && r_cmp_vld && (r_op == OP_SWEEP) &&
                        r_live[r_cmp_idx] && (add_sum > r_timeout);
    assign scan_end   = in_scan && !r_cmp_vld && (r_rd_idx >= r_used);
    // hold the read register once a hit is seen
    assign ram_re     = in_scan && (r_rd_idx < r_used) && !hit_now;

    always_comb begin
        n_state      = r_state;
        n_timeout    = i_cfg_we ? i_cfg_wdata : r_timeout;
        n_used       = r_used;
        n_live       = r_live;
        n_rd_idx     = r_rd_idx;
        n_cmp_vld    = r_cmp_vld;
        n_ovalid     = r_ovalid;
        n_op         = r_op;
        n_key        = r_key;
        n_len        = r_len;
        n_now        = r_now;
        n_cmp_idx    = r_cmp_idx;
        n_hit_idx    = r_hit_idx;
        n_exp        = r_exp;
        n_pkt_sum    = r_pkt_sum;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_res_pkt    = r_res_pkt;
        n_res_byte   = r_res_byte;
        n_res_exp    = r_res_exp;
        n_o_status   = r_o_status;
        n_o_idx      = r_o_idx;
        n_o_pkt      = r_o_pkt;
        n_o_byte     = r_o_byte;
        n_o_exp      = r_o_exp;
        ram_we       = 1'b0;
        ram_waddr    = r_hit_idx;
        ram_wdata    = rd_ent;

        if (out_xfer) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_op              = s_axis_tuser[0];
                    n_key.ip_ver      = s_axis_tuser[1];
                    n_key.protocol    = in_data.protocol;
                    n_key.source_port = in_data.source_port;
                    n_key.dest_port   = in_data.dest_port;
                    n_key.src_hi      = in_data.source_addr_hi;
                    n_key.src_lo      = in_data.source_addr_lo;
                    n_key.dst_hi      = in_data.dest_addr_hi;
                    n_key.dst_lo      = in_data.dest_addr_lo;
                    n_len             = in_data.pkt_len;
                    n_now             = in_data.now_ns;
                    n_rd_idx          = '0;
                    n_cmp_vld         = 1'b0;
                    n_exp             = '0;
                    n_state           = S_SCAN;
                end
            end
            S_SCAN: begin
                n_cmp_vld = ram_re;
                n_cmp_idx = r_rd_idx[IDX_W-1:0];
                if (ram_re) begin
                    n_rd_idx = r_rd_idx + USED_W'(1);
                end
                if (hit_now) begin
                    n_hit_idx = r_cmp_idx;
                    n_state   = S_PKT;
                end
                if (expire_now) begin
                    n_live[r_cmp_idx] = 1'b0;
                    n_exp             = r_exp + USED_W'(1);
                end
                if (scan_end) begin
                    n_res_idx  = '0;
                    n_res_pkt  = '0;
                    n_res_byte = '0;
                    n_res_exp  = '0;
                    n_state    = S_DONE;
                    if (r_op == OP_SWEEP) begin
                        n_res_status = ST_SWEEP;
                        n_res_exp    = EXP_W'(r_exp);
                    end else if (r_used < USED_W'(TABLE_DEPTH)) begin
                        // miss with room: append at the fill point
                        ram_we                 = 1'b1;
                        ram_waddr              = r_used[IDX_W-1:0];
                        ram_wdata.key          = r_key;
                        ram_wdata.stat.pkt_cnt = 64'd1;
                        ram_wdata.stat.byte_cnt = 64'(r_len);
                        ram_wdata.stat.last_ns = r_now;
                        n_live[r_used[IDX_W-1:0]] = 1'b1;
                        n_used                 = r_used + USED_W'(1);
                        n_res_status           = ST_NEW;
                        n_res_idx              = ENTRY_W'(r_used);
                        n_res_pkt              = 64'd1;
                        n_res_byte             = 64'(r_len);
                    end else begin
                        n_res_status = ST_FULL;
                    end
                end
            end
            S_PKT: begin
                n_pkt_sum = add_sum;
                n_state   = S_BYTE;
            end
            S_BYTE: begin
                ram_we                  = 1'b1;
                ram_waddr               = r_hit_idx;
                ram_wdata.key           = rd_ent.key;
                ram_wdata.stat.pkt_cnt  = r_pkt_sum;
                ram_wdata.stat.byte_cnt = add_sum;
                ram_wdata.stat.last_ns  = r_now;
                n_res_status            = ST_HIT;
                n_res_idx               = ENTRY_W'(r_hit_idx);
                n_res_pkt               = r_pkt_sum;
                n_res_byte              = add_sum;
                n_res_exp               = '0;
                n_state                 = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_o_status = r_res_status;
                    n_o_idx    = r_res_idx;
                    n_o_pkt    = r_res_pkt;
                    n_o_byte   = r_res_byte;
                    n_o_exp    = r_res_exp;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_timeout <= TIMEOUT_RESET;
            r_used    <= '0;
            r_live    <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_timeout <= n_timeout;
            r_used    <= n_used;
            r_live    <= n_live;
            r_rd_idx  <= n_rd_idx;
            r_cmp_vld <= n_cmp_vld;
            r_ovalid  <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_len        <= n_len;
        r_now        <= n_now;
        r_cmp_idx    <= n_cmp_idx;
        r_hit_idx    <= n_hit_idx;
        r_exp        <= n_exp;
        r_pkt_sum    <= n_pkt_sum;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_res_pkt    <= n_res_pkt;
        r_res_byte   <= n_res_byte;
        r_res_exp    <= n_res_exp;
        r_o_status   <= n_o_status;
        r_o_idx      <= n_o_idx;
        r_o_pkt      <= n_o_pkt;
        r_o_byte     <= n_o_byte;
        r_o_exp      <= n_o_exp;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - OUT_EXP_LSB - EXP_W)'(0),
        r_o_exp, r_o_byte, r_o_pkt, r_o_idx
    };

endmodule

### sv/ftue_ram.sv
// ----------------------------------------------------------------------------
// ftue_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read register holds when
// read enable is low.
// ----------------------------------------------------------------------------
module ftue_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ftue_chk.sv
// ----------------------------------------------------------------------------
// ftue_chk: port-level checks for the flow table
// Result field consistency per status, reset and stall behavior.
// ----------------------------------------------------------------------------
module ftue_chk
    import ftue_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    logic [63:0]      c_pkt;
    logic [EXP_W-1:0] c_exp;

    assign c_pkt = m_axis_tdata[OUT_PKT_LSB +: 64];
    assign c_exp = m_axis_tdata[OUT_EXP_LSB +: EXP_W];

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // sweep results carry only the expired count
    a_sweep_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_SWEEP) |->
            (m_axis_tdata[OUT_EXP_LSB-1:0] == '0))
        else $error("sweep result has nonzero index or counters");

    // update results never report expiries; a dropped packet reports nothing
    a_update_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_SWEEP) |->
            (c_exp == '0) && ((m_axis_tuser != ST_FULL) || (m_axis_tdata == '0)))
        else $error("update result fields inconsistent with status");

    // a fresh flow has counted exactly one packet
    a_new_one_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NEW) |-> (c_pkt == 64'd1))
        else $error("new flow packet count is not one");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind flow_table_update_expire ftue_chk u_ftue_chk (.*);

### tb/sv/flow_table_update_expire_test.sv
// ----------------------------------------------------------------------------
// flow_table_update_expire_test: self-checking bench for the flow table
// Runs a short directed table (key aliasing, expiry edges, timeout extremes),
// then random packet and sweep traffic that fills the table to overflow.
// Every result transfer is checked field by field against the local model or a directed row's expected values.
// ----------------------------------------------------------------------------
module flow_table_update_expire_test
    import ftue_pkg::*;
();

    localparam bit VER_IPV6    = 1'b1;
    localparam int STALL_LIMIT = 20 * (TABLE_DEPTH + 64);   // cycles with no transfer
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 110;

    // one result transfer, as the model sees it
    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] slot;
        logic [63:0]        pkts;
        logic [63:0]        octets;
        logic [EXP_W-1:0]   expired;
    } t_flow_result;

    typedef enum bit {ROW_ITEM, ROW_TIMEOUT} t_row_kind;

    // directed row; for ROW_TIMEOUT the now field carries the register value
    typedef struct {
        t_row_kind    kind;
        bit           op;
        t_key         key;
        logic [15:0]  len;
        logic [63:0]  now;
        bit           typed;
        t_flow_result want;
    } t_stim_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [63:0]            i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // protocol, ports, addresses, len, now
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;  // op, ip_ver
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // entry_index, pkt, byte, expired
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // status

    flow_table_update_expire DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Flow table model: live marks, keys, counters and last-seen times.
    // ------------------------------------------------------------------
    bit          entry_live   [TABLE_DEPTH];
    t_key        entry_key    [TABLE_DEPTH];
    logic [63:0] entry_pkts   [TABLE_DEPTH];
    logic [63:0] entry_octets [TABLE_DEPTH];
    logic [63:0] entry_seen   [TABLE_DEPTH];
    int unsigned slots_used   = 0;
    logic [63:0] idle_timeout = TIMEOUT_RESET;

    t_flow_result pending_results[$];   // expected results, oldest first
    t_stim_row    directed_rows[$];
    t_key         key_pool[$];          // fresh and near-miss update keys, for revisits
    int unsigned  fail_count = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  rx_stall_left = 0;
    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;

    // IPv4 keys only look at the low 32 bits of the lo address words
    function automatic bit same_flow(t_key a, t_key b);
        if ({a.ip_ver, a.protocol, a.source_port, a.dest_port} !=
            {b.ip_ver, b.protocol, b.source_port, b.dest_port})
            return 1'b0;
        if (a.ip_ver == VER_IPV4)
            return a.src_lo[31:0] == b.src_lo[31:0] && a.dst_lo[31:0] == b.dst_lo[31:0];
        return a.src_hi == b.src_hi && a.src_lo == b.src_lo &&
               a.dst_hi == b.dst_hi && a.dst_lo == b.dst_lo;
    endfunction

    function automatic t_flow_result predict_flow(bit op, t_key k, logic [15:0] len,
                                                  logic [63:0] now);
        t_flow_result r;
        logic [63:0]  idle;
        int unsigned  cleared;
        r = '0;
        cleared = 0;
        if (op == OP_SWEEP) begin
            // idle time wraps, so a clock that went backward looks very old
            for (int i = 0; i < slots_used; i++) begin
                idle = now - entry_seen[i];
                if (entry_live[i] && idle > idle_timeout) begin
                    entry_live[i] = 1'b0;
                    cleared++;
                end
            end
            r.status  = ST_SWEEP;
            r.expired = EXP_W'(cleared);
            return r;
        end
        for (int i = 0; i < slots_used; i++) begin
            if (entry_live[i] && same_flow(entry_key[i], k)) begin
                entry_pkts[i]   = entry_pkts[i] + 64'd1;
                entry_octets[i] = entry_octets[i] + {48'd0, len};
                entry_seen[i]   = now;
                r.status = ST_HIT;
                r.slot   = ENTRY_W'(i);
                r.pkts   = entry_pkts[i];
                r.octets = entry_octets[i];
                return r;
            end
        end
        // miss: append, slots freed by sweeps stay unused
        if (slots_used < TABLE_DEPTH) begin
            entry_key[slots_used]    = k;
            entry_pkts[slots_used]   = 64'd1;
            entry_octets[slots_used] = {48'd0, len};
            entry_seen[slots_used]   = now;
            entry_live[slots_used]   = 1'b1;
            r.status = ST_NEW;
            r.slot   = ENTRY_W'(slots_used);
            r.pkts   = 64'd1;
            r.octets = {48'd0, len};
            slots_used++;
            return r;
        end
        r.status = ST_FULL;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_key mk_key(bit ver, logic [7:0] proto, logic [15:0] sp,
                                    logic [15:0] dp, logic [63:0] shi, logic [63:0] slo,
                                    logic [63:0] dhi, logic [63:0] dlo);
        t_key k;
        k.ip_ver      = ver;
        k.protocol    = proto;
        k.source_port = sp;
        k.dest_port   = dp;
        k.src_hi      = shi;
        k.src_lo      = slo;
        k.dst_hi      = dhi;
        k.dst_lo      = dlo;
        return k;
    endfunction

    function automatic t_flow_result res(logic [1:0] st, int unsigned slot,
                                         logic [63:0] pkts, logic [63:0] octets,
                                         int unsigned expired);
        t_flow_result r;
        r.status  = st;
        r.slot    = ENTRY_W'(slot);
        r.pkts    = pkts;
        r.octets  = octets;
        r.expired = EXP_W'(expired);
        return r;
    endfunction

    function automatic void add_row(t_row_kind kind, bit op, t_key k, logic [15:0] len,
                                    logic [63:0] now, bit typed, t_flow_result want);
        t_stim_row row;
        row.kind  = kind;
        row.op    = op;
        row.key   = k;
        row.len   = len;
        row.now   = now;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly back to back, sometimes a few cycles, now and then a long pause
    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_key fresh_key();
        t_key k;
        k = mk_key(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 16'($urandom),
                   rand64(), rand64(), rand64(), rand64());
        // plain IPv4 traffic keeps the unused address bits at zero
        if (k.ip_ver == VER_IPV4 && $urandom_range(0, 1) == 0) begin
            k.src_hi = '0;
            k.dst_hi = '0;
            k.src_lo[63:32] = '0;
            k.dst_lo[63:32] = '0;
        end
        return k;
    endfunction

    // favor recently seen flows so that revisits land while still live
    function automatic t_key pool_key();
        int unsigned span;
        span = (key_pool.size() < 16) ? key_pool.size() : 16;
        if ($urandom_range(0, 3) == 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return key_pool[key_pool.size() - 1 - $urandom_range(0, span - 1)];
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // one transfer on the request stream; the model runs at acceptance
    task automatic send_flow_item(bit op, t_key k, logic [15:0] len, logic [63:0] now,
                                  bit typed, t_flow_result want);
        t_in_data     d;
        t_flow_result r;
        int unsigned  gap;
        d.protocol       = k.protocol;
        d.source_port    = k.source_port;
        d.dest_port      = k.dest_port;
        d.source_addr_hi = k.src_hi;
        d.source_addr_lo = k.src_lo;
        d.dest_addr_hi   = k.dst_hi;
        d.dest_addr_lo   = k.dst_lo;
        d.pkt_len        = len;
        d.now_ns         = now;
        gap = tx_idle_en ? idle_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= {k.ip_ver, op};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_flow(op, k, len, now);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_timeout(logic [63:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        idle_timeout = value;
    endtask

    // ------------------------------------------------------------------
    // Result side: random tready stalls and the field-by-field check.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_flow_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_axis_tuser));
                    check_field("entry_index", 64'(want.slot),
                                64'(m_axis_tdata[OUT_IDX_LSB +: ENTRY_W]));
                    check_field("packet_count", want.pkts, m_axis_tdata[OUT_PKT_LSB +: 64]);
                    check_field("byte_count", want.octets, m_axis_tdata[OUT_BYTE_LSB +: 64]);
                    check_field("expired_count", 64'(want.expired),
                                64'(m_axis_tdata[OUT_EXP_LSB +: EXP_W]));
                end
            end
            if (rx_stall_left != 0) begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                rx_stall_left = rx_idle_en ? idle_gap() : 0;
                m_axis_tready <= (rx_stall_left == 0);
            end
        end
    end

    // watchdog: a sweep of a full table plus the worst stalls stays far below
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("flow_table_update_expire: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_key         ka, ka_alias, kb, kb_hi, kc, kd, k;
        logic [63:0]  t, cur_time, now, tmo;
        logic [15:0]  len;
        bit           op;
        int unsigned  sel;

        t  = TIMEOUT_RESET;
        ka = mk_key(VER_IPV4, 8'd6, 16'd0, 16'hFFFF,
                    64'd0, 64'h0000_0000_0A00_0001, 64'd0, 64'h0000_0000_C0A8_0101);
        // same IPv4 flow, junk in the bits the key ignores
        ka_alias = mk_key(VER_IPV4, 8'd6, 16'd0, 16'hFFFF,
                          '1, 64'hFFFF_FFFF_0A00_0001,
                          64'h1234_5678_9ABC_DEF0, 64'hDEAD_BEEF_C0A8_0101);
        kb    = mk_key(VER_IPV6, 8'hFF, 16'hFFFF, 16'd0, '1, '1, '1, '1);
        kb_hi = mk_key(VER_IPV6, 8'hFF, 16'hFFFF, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF,
                       '1, '1, '1);
        // same fields as kb but tagged IPv4: must not alias onto kb
        kc = mk_key(VER_IPV4, 8'hFF, 16'hFFFF, 16'd0, '1, '1, '1, '1);
        kd = mk_key(VER_IPV4, 8'd0, 16'd0, 16'd0, '0, '0, '0, '0);

        // default timeout from reset
        add_row(ROW_ITEM, OP_UPDATE, ka, 16'hFFFF, 64'd0, 1, res(ST_NEW, 0, 1, 65535, 0));
        add_row(ROW_ITEM, OP_UPDATE, ka_alias, 16'd0, 64'd100, 1,
                res(ST_HIT, 0, 2, 65535, 0));
        add_row(ROW_ITEM, OP_UPDATE, kb, 16'd1, 64'd200, 1, res(ST_NEW, 1, 1, 1, 0));
        add_row(ROW_ITEM, OP_UPDATE, kb_hi, 16'd16, 64'd250, 1, res(ST_NEW, 2, 1, 16, 0));
        add_row(ROW_ITEM, OP_UPDATE, kc, 16'd1500, 64'd260, 1,
                res(ST_NEW, 3, 1, 1500, 0));
        add_row(ROW_ITEM, OP_UPDATE, kd, 16'd64, 64'd270, 1, res(ST_NEW, 4, 1, 64, 0));
        add_row(ROW_ITEM, OP_UPDATE, kb, 16'd0, 64'd300, 1, res(ST_HIT, 1, 2, 1, 0));
        // idle exactly equal to the timeout stays, one more ns expires
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, t + 64'd100, 1, res(ST_SWEEP, 0, 0, 0, 0));
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, t + 64'd101, 1, res(ST_SWEEP, 0, 0, 0, 1));
        add_row(ROW_ITEM, OP_UPDATE, ka, 16'd40, t + 64'd200, 1, res(ST_NEW, 5, 1, 40, 0));
        // zero timeout; slot 5 sees the clock go backward and wraps
        add_row(ROW_TIMEOUT, OP_UPDATE, '0, 16'd0, 64'd0, 0, '0);
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, 64'd300, 1, res(ST_SWEEP, 0, 0, 0, 4));
        // maximum timeout: nothing can expire
        add_row(ROW_TIMEOUT, OP_UPDATE, '0, 16'd0, '1, 0, '0);
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, 64'd0, 1, res(ST_SWEEP, 0, 0, 0, 0));
        add_row(ROW_ITEM, OP_UPDATE, kb, 16'hFFFF, '1, 1, res(ST_HIT, 1, 3, 65536, 0));
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, '1, 1, res(ST_SWEEP, 0, 0, 0, 0));
        add_row(ROW_ITEM, OP_UPDATE, kc, 16'd7, '1, 1, res(ST_NEW, 6, 1, 7, 0));
        add_row(ROW_ITEM, OP_UPDATE, ka_alias, 16'd9, 64'd5, 0, '0);
        add_row(ROW_TIMEOUT, OP_UPDATE, '0, 16'd0, 64'd1000, 0, '0);
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, 64'd500, 0, '0);
        add_row(ROW_ITEM, OP_SWEEP, '0, 16'd0, 64'd2000, 0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_TIMEOUT) begin
                drain_results();
                write_timeout(directed_rows[n].now);
            end else begin
                send_flow_item(directed_rows[n].op, directed_rows[n].key,
                               directed_rows[n].len, directed_rows[n].now,
                               directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // random phases: each starts idle with a new timeout; the table
        // fills up along the way and later misses are dropped
        cur_time = 64'd10000;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       tmo = 64'($urandom_range(4000, 30000));
                1:       tmo = '1;
                2:       tmo = rand64();
                3:       tmo = 64'($urandom_range(4000, 30000));
                default: tmo = 64'($urandom_range(500, 3000));
            endcase
            write_timeout(tmo);
            // one phase runs with no idling on either side
            tx_idle_en = (phase != 3);
            rx_idle_en = (phase != 3);
            if (phase == 2)
                cur_time = rand64();
            repeat (PHASE_ITEMS) begin
                cur_time += 64'($urandom_range(0, 3000));
                now = cur_time;
                if ($urandom_range(0, 49) == 0)
                    now = cur_time - 64'($urandom_range(1, 100000));
                len = 16'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    op = OP_SWEEP;
                    k  = fresh_key();      // key fields are don't-care on a sweep
                end else begin
                    op  = OP_UPDATE;
                    sel = $urandom_range(0, 99);
                    if (key_pool.size() == 0 || sel < 50) begin
                        k = fresh_key();
                        key_pool.push_back(k);
                    end else if (sel < 60) begin
                        // near miss: one compared bit differs from a known flow
                        k = pool_key();
                        case ($urandom_range(0, 4))
                            0: k.ip_ver = ~k.ip_ver;
                            1: k.protocol ^= 8'(1 << $urandom_range(0, 7));
                            2: k.source_port ^= 16'(1 << $urandom_range(0, 15));
                            3: k.dest_port ^= 16'(1 << $urandom_range(0, 15));
                            default: begin
                                if (k.ip_ver == VER_IPV4)
                                    k.dst_lo ^= 64'(1) << $urandom_range(0, 31);
                                else
                                    k.src_hi ^= 64'(1) << $urandom_range(0, 63);
                            end
                        endcase
                        key_pool.push_back(k);
                    end else begin
                        k = pool_key();
                        if (k.ip_ver == VER_IPV4 && $urandom_range(0, 1) == 0) begin
                            k.src_hi = rand64();
                            k.dst_hi = rand64();
                            k.src_lo[63:32] = $urandom;
                            k.dst_lo[63:32] = $urandom;
                        end
                    end
                end
                send_flow_item(op, k, len, now, 0, '0);
            end
        end

        drain_results();
        // catch any stray result after the last expected one
        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        if (fail_count == 0)
            $display("flow_table_update_expire: match");
        else
            $display("flow_table_update_expire: mismatch");
        $finish;
    end

endmodule
